@@ hw/rtl/rhc_pkg.sv @@
// Shared widths, scale constants and the divider request type for the RGB to HSL converter.
package rhc_pkg;

    localparam int CH_W          = 8;
    localparam int HUE_W         = 15;
    localparam int SAT_W         = 16;
    localparam int LIT_W         = 9;
    localparam int DVS_W         = 8;
    localparam int QUO_W         = 16;
    localparam int DVD_W         = DVS_W + QUO_W;
    localparam int FRONT_STAGES  = 3;

    localparam int HUE_SCALE     = 3840;
    localparam int SAT_SCALE     = 65535;
    localparam int FULL_SCALE    = 255;

    typedef struct packed {
        logic [DVD_W-1:0] hue_dvd;
        logic [DVS_W-1:0] hue_dvs;
        logic [DVD_W-1:0] sat_dvd;
        logic [DVS_W-1:0] sat_dvs;
        logic [LIT_W-1:0] lightness;
    } t_div_req;

endpackage

@@ hw/rtl/rgb_to_hsl_converter.sv @@
// RGB to HSL converter: 8-bit red/green/blue in, fixed-point hue/saturation/lightness out.
// Accepts one word per clock and delivers one result word per clock while i_stall is low;
// each word passes through three front stages (max/min and sextant pick, hue numerator
// and saturation divisor, dividend products) and sixteen stages of the two restoring
// dividers, which run side by side and produce one quotient bit per stage. Hue is in 1/64
// degree (0..23039), saturation is 65535 for 1.0, lightness is max+min (0..510); a grey
// pixel gives hue 0 and saturation 0. Each stage has its own valid bit and moves whenever
// the stage after it is free, so bubbles are squeezed out while the output is stalled.
module rgb_to_hsl_converter (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [rhc_pkg::CH_W-1:0]        i_red,
    input  logic [rhc_pkg::CH_W-1:0]        i_green,
    input  logic [rhc_pkg::CH_W-1:0]        i_blue,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [rhc_pkg::HUE_W-1:0]       o_hue,
    output logic [rhc_pkg::SAT_W-1:0]       o_saturation,
    output logic [rhc_pkg::LIT_W-1:0]       o_lightness
);
    import rhc_pkg::*;

    localparam int NS = FRONT_STAGES + QUO_W;

    logic [NS-1:0]      r_vld, n_vld, w_ready;
    t_div_req           w_req;
    logic [QUO_W-1:0]   w_hue_q, w_sat_q;
    logic [LIT_W-1:0]   r_lit [QUO_W];
    logic [LIT_W-1:0]   n_lit [QUO_W];

    // a stage may load unless it and every stage after it are full and the output is held
    genvar k;
    generate
        for (k = 0; k < NS; k++) begin : g_ready
            assign w_ready[k] = ~(&r_vld[NS-1:k]) | ~i_stall;
        end
    endgenerate

    assign n_vld = {r_vld[NS-2:0], i_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int s = 0; s < NS; s++) begin
                if (w_ready[s]) r_vld[s] <= n_vld[s];
            end
        end
    end

    rhc_front u_front (
        .i_clk   (i_clk),
        .i_en    (w_ready[FRONT_STAGES-1:0]),
        .i_red   (i_red),
        .i_green (i_green),
        .i_blue  (i_blue),
        .o_req   (w_req)
    );

    rhc_pipe_div #(
        .DVS_W (DVS_W),
        .Q_W   (QUO_W)
    ) u_hue_div (
        .i_clk      (i_clk),
        .i_en       (w_ready[NS-1:FRONT_STAGES]),
        .i_dividend (w_req.hue_dvd),
        .i_divisor  (w_req.hue_dvs),
        .o_quotient (w_hue_q)
    );

    rhc_pipe_div #(
        .DVS_W (DVS_W),
        .Q_W   (QUO_W)
    ) u_sat_div (
        .i_clk      (i_clk),
        .i_en       (w_ready[NS-1:FRONT_STAGES]),
        .i_dividend (w_req.sat_dvd),
        .i_divisor  (w_req.sat_dvs),
        .o_quotient (w_sat_q)
    );

    // carry lightness alongside the divider stages
    always_comb begin
        n_lit[0] = w_req.lightness;
        for (int s = 1; s < QUO_W; s++) n_lit[s] = r_lit[s-1];
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < QUO_W; s++) begin
            if (w_ready[FRONT_STAGES+s]) r_lit[s] <= n_lit[s];
        end
    end

    assign o_stall      = ~w_ready[0];
    assign o_valid      = r_vld[NS-1];
    assign o_hue        = w_hue_q[HUE_W-1:0];
    assign o_saturation = w_sat_q[SAT_W-1:0];
    assign o_lightness  = r_lit[QUO_W-1];

`ifndef NO_ASSERTIONS
    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (w_hue_q < QUO_W'(6 * HUE_SCALE)))
        else $error("hue quotient out of range");

    a_black_white: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_lightness == '0 || o_lightness == LIT_W'(2 * FULL_SCALE)))
        |-> (o_hue == '0 && o_saturation == '0))
        else $error("black or white pixel with nonzero hue or saturation");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("stalled result word dropped");

    a_bubble_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[0] |-> !o_stall)
        else $error("input stalled while the first stage is empty");
`endif

endmodule

@@ hw/rtl/rhc_front.sv @@
// Front stages: max/min and sextant pick, hue numerator and saturation divisor, dividends.
module rhc_front (
    input  logic                                i_clk,
    input  logic [rhc_pkg::FRONT_STAGES-1:0]    i_en,
    input  logic [rhc_pkg::CH_W-1:0]            i_red,
    input  logic [rhc_pkg::CH_W-1:0]            i_green,
    input  logic [rhc_pkg::CH_W-1:0]            i_blue,
    output rhc_pkg::t_div_req                   o_req
);
    import rhc_pkg::*;

    localparam int NUM_W  = 11;
    localparam int SEXT_W = 3;
    localparam logic [SEXT_W-1:0] SEXT_RED   = 3'd0;
    localparam logic [SEXT_W-1:0] SEXT_GREEN = 3'd2;
    localparam logic [SEXT_W-1:0] SEXT_BLUE  = 3'd4;
    localparam logic [SEXT_W-1:0] SEXT_WRAP  = 3'd6;

    // stage 1
    logic [CH_W-1:0]        n_mx, n_mn, r_mx, r_mn;
    logic signed [CH_W:0]   n_diff, r_diff;
    logic [SEXT_W-1:0]      n_sext, r_sext;

    // stage 2
    logic [CH_W-1:0]        n_d, r_d;
    logic [LIT_W-1:0]       n_sum, r_sum;
    logic [DVS_W-1:0]       n_den, r_den;
    logic [NUM_W-1:0]       n_num, r_num;

    t_div_req               n_req, r_req;

    logic signed [CH_W:0]   w_dgb, w_dbr, w_drg;
    logic signed [NUM_W:0]  w_num_s;

    assign w_dgb = $signed({1'b0, i_green}) - $signed({1'b0, i_blue});
    assign w_dbr = $signed({1'b0, i_blue})  - $signed({1'b0, i_red});
    assign w_drg = $signed({1'b0, i_red})   - $signed({1'b0, i_green});

    always_comb begin
        // ties go to red, then green
        if (i_red >= i_green && i_red >= i_blue) begin
            n_mx   = i_red;
            n_diff = w_dgb;
            n_sext = w_dgb[CH_W] ? SEXT_WRAP : SEXT_RED;
        end else if (i_green >= i_blue) begin
            n_mx   = i_green;
            n_diff = w_dbr;
            n_sext = SEXT_GREEN;
        end else begin
            n_mx   = i_blue;
            n_diff = w_drg;
            n_sext = SEXT_BLUE;
        end
        n_mn = i_red;
        if (i_green < n_mn) n_mn = i_green;
        if (i_blue < n_mn)  n_mn = i_blue;
    end

    always_comb begin
        n_d     = r_mx - r_mn;
        n_sum   = LIT_W'(r_mx) + LIT_W'(r_mn);
        n_den   = (n_sum <= LIT_W'(FULL_SCALE)) ? n_sum[DVS_W-1:0]
                                                : DVS_W'(LIT_W'(2 * FULL_SCALE) - n_sum);
        w_num_s = $signed({1'b0, NUM_W'(r_sext) * NUM_W'(n_d)}) + (NUM_W+1)'(r_diff);
        n_num   = w_num_s[NUM_W-1:0];
    end

    always_comb begin
        n_req.lightness = r_sum;
        if (r_d == '0) begin
            // grey: zero over one gives zero for both
            n_req.hue_dvd = '0;
            n_req.hue_dvs = DVS_W'(1);
            n_req.sat_dvd = '0;
            n_req.sat_dvs = DVS_W'(1);
        end else begin
            n_req.hue_dvd = DVD_W'(r_num) * DVD_W'(HUE_SCALE);
            n_req.hue_dvs = r_d;
            n_req.sat_dvd = DVD_W'(r_d) * DVD_W'(SAT_SCALE);
            n_req.sat_dvs = r_den;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_mx   <= n_mx;
            r_mn   <= n_mn;
            r_diff <= n_diff;
            r_sext <= n_sext;
        end
        if (i_en[1]) begin
            r_d   <= n_d;
            r_sum <= n_sum;
            r_den <= n_den;
            r_num <= n_num;
        end
        if (i_en[2]) begin
            r_req <= n_req;
        end
    end

    assign o_req = r_req;

endmodule

@@ hw/rtl/rhc_pipe_div.sv @@
// Pipelined restoring divider: one quotient bit per register stage.
module rhc_pipe_div #(
    parameter int DVS_W = rhc_pkg::DVS_W,
    parameter int Q_W   = rhc_pkg::QUO_W
) (
    input  logic                    i_clk,
    input  logic [Q_W-1:0]          i_en,
    input  logic [DVS_W+Q_W-1:0]    i_dividend,
    input  logic [DVS_W-1:0]        i_divisor,
    output logic [Q_W-1:0]          o_quotient
);
    // the dividend's top DVS_W bits must be below the divisor

    logic [DVS_W-1:0] r_rem [Q_W];
    logic [Q_W-1:0]   r_lo  [Q_W];
    logic [DVS_W-1:0] r_dvs [Q_W];
    logic [Q_W-1:0]   r_quo [Q_W];

    logic [DVS_W-1:0] w_rem [Q_W];
    logic [Q_W-1:0]   w_lo  [Q_W];
    logic [DVS_W-1:0] w_dvs [Q_W];
    logic [Q_W-1:0]   w_quo [Q_W];

    genvar g;
    generate
        for (g = 0; g < Q_W; g++) begin : g_stage
            logic [DVS_W:0]   w_trial;
            logic             w_ge;
            logic [DVS_W-1:0] n_rem;
            logic [Q_W-1:0]   n_lo;
            logic [Q_W-1:0]   n_quo;

            if (g == 0) begin : g_head
                assign w_rem[g] = i_dividend[DVS_W+Q_W-1:Q_W];
                assign w_lo[g]  = i_dividend[Q_W-1:0];
                assign w_dvs[g] = i_divisor;
                assign w_quo[g] = '0;
            end else begin : g_body
                assign w_rem[g] = r_rem[g-1];
                assign w_lo[g]  = r_lo[g-1];
                assign w_dvs[g] = r_dvs[g-1];
                assign w_quo[g] = r_quo[g-1];
            end

            always_comb begin
                // bring down the next dividend bit, subtract if it fits
                w_trial = {w_rem[g], w_lo[g][Q_W-1]};
                w_ge    = w_trial >= {1'b0, w_dvs[g]};
                n_rem   = w_ge ? DVS_W'(w_trial - {1'b0, w_dvs[g]}) : w_trial[DVS_W-1:0];
                n_lo    = w_lo[g] << 1;
                n_quo   = (w_quo[g] << 1) | Q_W'(w_ge);
            end

            always_ff @(posedge i_clk) begin
                if (i_en[g]) begin
                    r_rem[g] <= n_rem;
                    r_lo[g]  <= n_lo;
                    r_dvs[g] <= w_dvs[g];
                    r_quo[g] <= n_quo;
                end
            end
        end
    endgenerate

    assign o_quotient = r_quo[Q_W-1];

endmodule
